/* hw/rtl/dtoa_pkg.sv */
package dtoa_pkg;

  // stream payload widths, whole bytes
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 40;

  // field widths
  localparam int unsigned DayW        = 5;
  localparam int unsigned MonthW      = 4;
  localparam int unsigned YearFieldW  = 14;
  localparam int unsigned DayOffFldW  = 16;
  localparam int unsigned HourW       = 5;
  localparam int unsigned MinW        = 6;
  localparam int unsigned SecW        = 6;
  localparam int unsigned AddHourW    = 8;

  // time carries
  localparam logic [5:0] SecPerMin  = 6'd60;
  localparam logic [5:0] MinPerHour = 6'd60;
  localparam logic [4:0] HourPerDay = 5'd24;

  // calendar constants
  localparam logic [3:0] MonthJan  = 4'd1;
  localparam logic [3:0] MonthFeb  = 4'd2;
  localparam logic [3:0] MonthDec  = 4'd12;
  localparam logic [4:0] LeapFebLen = 5'd29;

  typedef logic [DayW-1:0]   day_t;
  typedef logic [MonthW-1:0] month_t;

  localparam day_t MonthLenTab [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // days in a month, month taken as 1..12
  function automatic day_t month_len(month_t m, logic leap);
    month_t idx;
    idx = m - MonthJan;
    if (m == MonthFeb && leap) begin
      return LeapFebLen;
    end else if (idx < MonthDec) begin
      return MonthLenTab[idx];
    end else begin
      return 5'd31;
    end
  endfunction

endpackage

/* hw/rtl/dtoa_sub_unit.sv */
module dtoa_sub_unit #(
  parameter int unsigned Width = 17
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] diff_o,
  output logic             borrow_o,
  output logic             zero_o
);

  logic [Width:0] full;

  // shared subtract with borrow and zero flag
  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[Width-1:0];
  assign borrow_o = full[Width];
  assign zero_o   = (full[Width-1:0] == '0);

endmodule

/* hw/rtl/date_time_offset_adder.sv */
// sequence: after accept, seconds carry into minutes, minutes into hours, hours
//   into the day count, then the day count is walked off month by month and the
//   result is held until taken
// throughput: a new item is accepted only when idle, after the last result is
//   taken; the month walk runs through the shared subtract unit, one month a step
// reset: rst_ni clears the sequencer to idle; no result is pending after reset
module date_time_offset_adder #(
  parameter int unsigned DAY_OFFSET_BITS = 16,
  parameter int unsigned YEAR_BITS       = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // start_day, start_month, start_year, day_offset, start_hour, start_minute,
  // start_second, add_hours, add_minutes, add_seconds, zero pad
  input  logic [dtoa_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // end_day, end_month, end_year, end_hour, end_minute, end_second
  output logic [dtoa_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready
);

  import dtoa_pkg::*;

  localparam int unsigned UnitW  = DAY_OFFSET_BITS + 1;
  localparam int unsigned DoUsed = (DAY_OFFSET_BITS < DayOffFldW) ? DAY_OFFSET_BITS
                                                                  : DayOffFldW;
  localparam int unsigned YUsed  = (YEAR_BITS < YearFieldW) ? YEAR_BITS : YearFieldW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSec  = 3'd1;
  localparam logic [2:0] StMin  = 3'd2;
  localparam logic [2:0] StHour = 3'd3;
  localparam logic [2:0] StWalk = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]           state_q, state_d;
  day_t                 day_q, day_d;
  month_t               month_q, month_d;
  logic [YEAR_BITS-1:0] year_q, year_d;
  logic [UnitW-1:0]     days_q, days_d;
  logic [8:0]           hour_q, hour_d;
  logic [7:0]           min_q, min_d;
  logic [6:0]           sec_q, sec_d;

  // input fields
  day_t                 in_day;
  month_t               in_month;
  logic [YearFieldW-1:0] in_year;
  logic [DayOffFldW-1:0] in_days;
  logic [HourW-1:0]     in_hour;
  logic [MinW-1:0]      in_min;
  logic [SecW-1:0]      in_sec;
  logic [AddHourW-1:0]  in_add_h;
  logic [MinW-1:0]      in_add_m;
  logic [SecW-1:0]      in_add_s;

  assign in_day   = s_axis_tdata[4:0];
  assign in_month = s_axis_tdata[8:5];
  assign in_year  = s_axis_tdata[22:9];
  assign in_days  = s_axis_tdata[38:23];
  assign in_hour  = s_axis_tdata[43:39];
  assign in_min   = s_axis_tdata[49:44];
  assign in_sec   = s_axis_tdata[55:50];
  assign in_add_h = s_axis_tdata[63:56];
  assign in_add_m = s_axis_tdata[69:64];
  assign in_add_s = s_axis_tdata[75:70];

  // start date clamped into range
  logic [YEAR_BITS-1:0] ld_year;
  month_t               ld_month;
  day_t                 ld_len;
  day_t                 ld_day;

  always_comb begin
    ld_year = YEAR_BITS'(in_year[YUsed-1:0]);
    if (in_month < MonthJan) begin
      ld_month = MonthJan;
    end else if (in_month > MonthDec) begin
      ld_month = MonthDec;
    end else begin
      ld_month = in_month;
    end
    ld_len = month_len(ld_month, ld_year[1:0] == 2'b00);
    if (in_day == '0) begin
      ld_day = 5'd1;
    end else if (in_day > ld_len) begin
      ld_day = ld_len;
    end else begin
      ld_day = in_day;
    end
  end

  // walk step operands
  day_t walk_len;
  day_t walk_rem;

  assign walk_len = month_len(month_q, year_q[1:0] == 2'b00);
  assign walk_rem = walk_len - day_q;

  // shared subtract unit, operands picked by state
  logic [UnitW-1:0] unit_a, unit_b, unit_diff;
  logic             unit_borrow, unit_zero;

  always_comb begin
    case (state_q)
      StSec: begin
        unit_a = UnitW'(sec_q);
        unit_b = UnitW'(SecPerMin);
      end
      StMin: begin
        unit_a = UnitW'(min_q);
        unit_b = UnitW'(MinPerHour);
      end
      StHour: begin
        unit_a = UnitW'(hour_q);
        unit_b = UnitW'(HourPerDay);
      end
      default: begin
        unit_a = days_q;
        unit_b = UnitW'(walk_rem);
      end
    endcase
  end

  dtoa_sub_unit #(
    .Width (UnitW)
  ) u_sub (
    .a_i      (unit_a),
    .b_i      (unit_b),
    .diff_o   (unit_diff),
    .borrow_o (unit_borrow),
    .zero_o   (unit_zero)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    days_d  = days_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          day_d   = ld_day;
          month_d = ld_month;
          year_d  = ld_year;
          days_d  = UnitW'(in_days[DoUsed-1:0]);
          sec_d   = 7'(in_sec) + 7'(in_add_s);
          min_d   = 8'(in_min) + 8'(in_add_m);
          hour_d  = 9'(in_hour) + 9'(in_add_h);
          state_d = StSec;
        end
      end
      // seconds carry into minutes
      StSec: begin
        if (!unit_borrow) begin
          sec_d = unit_diff[6:0];
          min_d = min_q + 8'd1;
        end else begin
          state_d = StMin;
        end
      end
      // minutes carry into hours
      StMin: begin
        if (!unit_borrow) begin
          min_d  = unit_diff[7:0];
          hour_d = hour_q + 9'd1;
        end else begin
          state_d = StHour;
        end
      end
      // hours carry into the day count
      StHour: begin
        if (!unit_borrow) begin
          hour_d = unit_diff[8:0];
          days_d = days_q + UnitW'(1);
        end else begin
          state_d = StWalk;
        end
      end
      // one month per step
      StWalk: begin
        if (days_q == '0) begin
          state_d = StOut;
        end else if (!unit_borrow && !unit_zero) begin
          days_d = unit_diff;
          day_d  = '0;
          if (month_q == MonthDec) begin
            month_d = MonthJan;
            year_d  = year_q + YEAR_BITS'(1);
          end else begin
            month_d = month_q + 4'd1;
          end
        end else begin
          day_d  = day_q + days_q[4:0];
          days_d = '0;
        end
      end
      StOut: begin
        if (m_axis_tready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    days_q  <= days_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
  end

  // handshake and result item
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {sec_q[5:0], min_q[5:0], hour_q[4:0],
                          YearFieldW'(year_q), month_q, day_q};

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import dtoa_pkg::*;

  localparam int unsigned ClkHalf       = 6;
  localparam int unsigned ResetCycles   = 2;
  localparam int unsigned MaxIdle       = 13;
  localparam int unsigned RandomItems   = 250;
  localparam int unsigned DrainCycles   = 100;
  localparam int unsigned WatchdogLimit = 25000;
  localparam int unsigned MaxPrinted    = 40;
  localparam int unsigned YearModulus   = 1 << YearFieldW;
  localparam int unsigned HoursPerDay   = HourPerDay;

  // one date/time request for the input stream, with a flag to wait until no result is expected
  typedef struct packed {
    logic [DayW-1:0]       start_day;
    logic [MonthW-1:0]     start_month;
    logic [YearFieldW-1:0] start_year;
    logic [DayOffFldW-1:0] day_offset;
    logic [HourW-1:0]      start_hour;
    logic [MinW-1:0]       start_minute;
    logic [SecW-1:0]       start_second;
    logic [AddHourW-1:0]   add_hours;
    logic [MinW-1:0]       add_minutes;
    logic [SecW-1:0]       add_seconds;
    logic                  wait_for_idle;
  } date_time_req_t;

  // resulting end date and time
  typedef struct packed {
    logic [DayW-1:0]       end_day;
    logic [MonthW-1:0]     end_month;
    logic [YearFieldW-1:0] end_year;
    logic [HourW-1:0]      end_hour;
    logic [MinW-1:0]       end_minute;
    logic [SecW-1:0]       end_second;
  } date_time_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // start_day, start_month, start_year, day_offset, start_hour, start_minute,
  // start_second, add_hours, add_minutes, add_seconds, zero pad
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // end_day, end_month, end_year, end_hour, end_minute, end_second
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  date_time_req_t pending_requests [$];
  date_time_res_t expected_end_dates [$];
  date_time_req_t next_req;
  date_time_req_t in_flight_req;
  date_time_res_t want_res;

  int unsigned total_requests = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_stall     = 0;
  int unsigned stall_draw;
  int unsigned idle_cycles    = 0;
  bit          send_burst     = 1'b0;
  bit          recv_burst     = 1'b0;

  date_time_offset_adder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // length of a month, leap february every fourth year
  function automatic int unsigned days_in_month(int unsigned mon, int unsigned yr);
    if (mon == MonthFeb) begin
      return (yr % 4 == 0) ? LeapFebLen : 28;
    end
    case (mon)
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // time carries first, then walk month by month from the clamped start date
  function automatic date_time_res_t predict_end_date_time(date_time_req_t rq);
    int unsigned sec;
    int unsigned mnt;
    int unsigned hr;
    int unsigned days;
    int unsigned dd;
    int unsigned mm;
    int unsigned yy;
    int unsigned rem;
    date_time_res_t res;
    sec  = rq.start_second + rq.add_seconds;
    mnt  = rq.start_minute + rq.add_minutes + sec / SecPerMin;
    sec  = sec % SecPerMin;
    hr   = rq.start_hour + rq.add_hours + mnt / MinPerHour;
    mnt  = mnt % MinPerHour;
    days = rq.day_offset + hr / HoursPerDay;
    hr   = hr % HoursPerDay;
    mm = rq.start_month;
    if (mm < MonthJan) mm = MonthJan;
    if (mm > MonthDec) mm = MonthDec;
    yy = rq.start_year;
    dd = rq.start_day;
    if (dd < 1) dd = 1;
    if (dd > days_in_month(mm, yy)) dd = days_in_month(mm, yy);
    // day 0 means just before the first of the month
    while (days > 0) begin
      rem = days_in_month(mm, yy) - dd;
      if (days > rem) begin
        days = days - rem;
        dd   = 0;
        if (mm == MonthDec) begin
          mm = MonthJan;
          yy = (yy + 1) % YearModulus;
        end else begin
          mm = mm + 1;
        end
      end else begin
        dd   = dd + days;
        days = 0;
      end
    end
    res.end_day    = DayW'(dd);
    res.end_month  = MonthW'(mm);
    res.end_year   = YearFieldW'(yy);
    res.end_hour   = HourW'(hr);
    res.end_minute = MinW'(mnt);
    res.end_second = SecW'(sec);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch(what, 64'(got), 64'(want));
    end
  endtask

  task automatic add_request(int unsigned d, int unsigned mo, int unsigned y,
                             int unsigned off, int unsigned h, int unsigned mi,
                             int unsigned s, int unsigned ah, int unsigned am,
                             int unsigned as_, bit hold);
    date_time_req_t rq;
    rq.start_day     = DayW'(d);
    rq.start_month   = MonthW'(mo);
    rq.start_year    = YearFieldW'(y);
    rq.day_offset    = DayOffFldW'(off);
    rq.start_hour    = HourW'(h);
    rq.start_minute  = MinW'(mi);
    rq.start_second  = SecW'(s);
    rq.add_hours     = AddHourW'(ah);
    rq.add_minutes   = MinW'(am);
    rq.add_seconds   = SecW'(as_);
    rq.wait_for_idle = hold;
    pending_requests.push_back(rq);
  endtask

  // mostly calendar-valid requests, some raw bit patterns; small offsets keep
  // the month walk short, a few full-width ones reach far ahead
  task automatic add_random_request(bit hold);
    int unsigned off;
    int unsigned yr;
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) begin
      off = 0;
    end else if (pick <= 2) begin
      off = $urandom_range(65535);
    end else begin
      off = $urandom_range(1500);
    end
    yr = ($urandom_range(9) == 0) ? $urandom_range(YearModulus - 1, YearModulus - 4)
                                  : $urandom_range(9999);
    if ($urandom_range(9) < 7) begin
      add_request($urandom_range(31, 1), $urandom_range(12, 1), yr, off,
                  $urandom_range(23), $urandom_range(59), $urandom_range(59),
                  $urandom_range(255), $urandom_range(59), $urandom_range(59), hold);
    end else begin
      add_request($urandom_range(31), $urandom_range(15), $urandom_range(YearModulus - 1),
                  off, $urandom_range(31), $urandom_range(63), $urandom_range(63),
                  $urandom_range(255), $urandom_range(63), $urandom_range(63), hold);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_end_dates.push_back(predict_end_date_time(in_flight_req));
        accepted_count++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the item until taken
      end else if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].wait_for_idle && expected_end_dates.size() != 0)) begin
        next_req = pending_requests.pop_front();
        in_flight_req <= next_req;
        s_axis_tdata  <= {4'b0, next_req.add_seconds, next_req.add_minutes,
                          next_req.add_hours, next_req.start_second, next_req.start_minute,
                          next_req.start_hour, next_req.day_offset, next_req.start_year,
                          next_req.start_month, next_req.start_day};
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(15) == 0) send_burst = !send_burst;
        send_gap      <= send_burst ? 0 : $urandom_range(MaxIdle);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_end_dates.size() == 0) begin
          report_mismatch("result with none expected, tdata", 64'(m_axis_tdata), 0);
        end else begin
          want_res = expected_end_dates.pop_front();
          check_field("end_day",    32'(m_axis_tdata[4:0]),   32'(want_res.end_day));
          check_field("end_month",  32'(m_axis_tdata[8:5]),   32'(want_res.end_month));
          check_field("end_year",   32'(m_axis_tdata[22:9]),  32'(want_res.end_year));
          check_field("end_hour",   32'(m_axis_tdata[27:23]), 32'(want_res.end_hour));
          check_field("end_minute", 32'(m_axis_tdata[33:28]), 32'(want_res.end_minute));
          check_field("end_second", 32'(m_axis_tdata[39:34]), 32'(want_res.end_second));
        end
        if ($urandom_range(15) == 0) recv_burst = !recv_burst;
        stall_draw = recv_burst ? 0 : $urandom_range(MaxIdle);
        recv_stall    <= stall_draw;
        m_axis_tready <= (stall_draw == 0);
      end else if (recv_stall != 0) begin
        recv_stall    <= recv_stall - 1;
        m_axis_tready <= (recv_stall == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // directed: clamps, leap years, year wrap, carries, extremes
    add_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(31, 12, 9999, 0, 23, 59, 59, 0, 0, 0, 1'b0);
    add_request(31, 12, YearModulus - 1, 1, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(28, 2, 2024, 1, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(28, 2, 2023, 1, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(29, 2, 2023, 0, 6, 0, 0, 0, 0, 0, 1'b0);
    add_request(31, 4, 2021, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(15, 0, 2020, 10, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(15, 13, 2020, 10, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(31, 15, 2020, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(1, 1, 2000, 0, 23, 59, 59, 0, 0, 1, 1'b0);
    add_request(1, 1, 2000, 0, 31, 63, 63, 255, 63, 63, 1'b0);
    add_request(1, 1, 2000, 65535, 12, 0, 0, 0, 0, 0, 1'b0);
    add_request(31, 1, 2021, 29, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(5, 7, 1999, 365, 10, 30, 0, 48, 30, 30, 1'b1);
    add_request(31, 12, 2023, 366, 0, 0, 0, 24, 0, 0, 1'b0);
    add_request(1, 1, 0, 1461, 0, 0, 0, 0, 0, 0, 1'b0);
    add_request(30, 11, 16380, 65535, 23, 59, 59, 255, 59, 59, 1'b0);
    for (int i = 0; i < RandomItems; i++) begin
      add_random_request(i % 60 == 59);
    end
    total_requests = pending_requests.size();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_requests) @(posedge clk_i);
    while (expected_end_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* date_time_offset_adder.f */
hw/rtl/dtoa_pkg.sv
hw/rtl/dtoa_sub_unit.sv
hw/rtl/date_time_offset_adder.sv
bench/testbench.sv
